// File: rtl/vla_pkg.sv
// Shared types, constants and arithmetic helpers for the four-lane vector ALU.
// No dependencies; every other file imports this package.
package vla_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int TOL_BITS    = 16;
  localparam int LANES       = 4;
  localparam int PROD_BITS   = 2 * WORD_BITS;
  localparam int ACC_BITS    = PROD_BITS + 2;
  localparam int ROOT_BITS   = ACC_BITS / 2;
  localparam int REM_BITS    = ROOT_BITS + 2;
  localparam int SQRT_STAGES = ROOT_BITS;
  localparam int QUO_BITS    = FRAC_BITS + 1;
  localparam int DIVD_BITS   = WORD_BITS + FRAC_BITS + 1;
  localparam int TRIAL_BITS  = DIVD_BITS + 1;
  localparam int DIV_STAGES  = QUO_BITS + 1;
  localparam int MZ_TAP      = SQRT_STAGES;
  localparam int SIDE_DEPTH  = MZ_TAP + DIV_STAGES + 1;

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(7);

  localparam logic signed [ACC_BITS-1:0] WMAX_ACC =
    {{(ACC_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] WMIN_ACC = ~WMAX_ACC;
  localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1) << (FRAC_BITS-1);

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_SCALE, OP_NEG, OP_DOT, OP_MAG, OP_NORM, OP_CMP
  } op_e;

  typedef struct packed {
    op_e                         operation;
    logic signed [WORD_BITS-1:0] a_x;
    logic signed [WORD_BITS-1:0] a_y;
    logic signed [WORD_BITS-1:0] a_z;
    logic signed [WORD_BITS-1:0] a_w;
    logic signed [WORD_BITS-1:0] b_x;
    logic signed [WORD_BITS-1:0] b_y;
    logic signed [WORD_BITS-1:0] b_z;
    logic signed [WORD_BITS-1:0] b_w;
    logic signed [WORD_BITS-1:0] scale_factor;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] r_x;
    logic signed [WORD_BITS-1:0] r_y;
    logic signed [WORD_BITS-1:0] r_z;
    logic signed [WORD_BITS-1:0] r_w;
    logic signed [WORD_BITS-1:0] scalar_out;
    logic                        exact_equal;
    logic                        near_equal;
    logic                        zero_length_error;
  } out_item_t;

  // Everything that rides alongside the square root and divider pipelines.
  typedef struct packed {
    logic                              valid;
    op_e                               op;
    logic [LANES-1:0][WORD_BITS-1:0]   vec;
    logic [WORD_BITS-1:0]              scalar;
    logic                              eq;
    logic                              near;
    logic [LANES-1:0]                  aneg;
    logic [LANES-1:0][WORD_BITS-1:0]   amag;
    logic                              mzero;
  } side_t;

  function automatic logic signed [WORD_BITS-1:0] sat_word(
    input logic signed [ACC_BITS-1:0] x);
    logic signed [ACC_BITS-1:0] c;
    c = x;
    if (x > WMAX_ACC) c = WMAX_ACC;
    if (x < WMIN_ACC) c = WMIN_ACC;
    return c[WORD_BITS-1:0];
  endfunction

  // Drop the fraction bits, round to nearest with ties toward +inf.
  function automatic logic signed [ACC_BITS-1:0] round_frac(
    input logic signed [ACC_BITS-1:0] x);
    return (x + RND_HALF) >>> FRAC_BITS;
  endfunction

endpackage

// File: rtl/four_lane_vector_alu_top.sv
// Four-lane Q16.16 vector ALU: add, sub, scale, negate, dot, magnitude,
// normalize and compare. One item per clock cycle while the output is not
// stalled; the pipeline depth is set by the 33-stage square root followed
// by the 18-stage per-lane divider used by normalize; every operation takes
// the same path so results leave in order. A stalled output holds the whole
// pipeline. Depends on vla_pkg, vla_lane, vla_sqrt, vla_div.
module four_lane_vector_alu_top import vla_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TOL_BITS-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o
);

  logic                 adv;
  logic [TOL_BITS-1:0]  tol_q;

  logic [LANES-1:0][WORD_BITS-1:0] a_v, b_v;
  logic signed [WORD_BITS-1:0] lvec  [LANES];
  logic signed [PROD_BITS-1:0] lprod [LANES];
  logic [LANES-1:0]            leq, lnear, laneg;
  logic [LANES-1:0][WORD_BITS-1:0] lamag;

  logic v1_q, v2_q, vp_q, vt_q;
  op_e  op1_q, op2_q, opp_q, opt_q;
  logic signed [ACC_BITS-1:0] pair0_q, pair1_q, total_q;
  logic [LANES-1:0][WORD_BITS-1:0] vecp_q, vect_q, amagp_q, amagt_q;
  logic [LANES-1:0] anegp_q, anegt_q;
  logic eqp_q, eqt_q, nearp_q, neart_q;

  side_t side_in, side_patch;
  side_t side_q [SIDE_DEPTH];

  logic [ROOT_BITS-1:0] root_c, m_c, m_q;
  logic [REM_BITS-1:0]  rem_c;
  logic [QUO_BITS-1:0]  dq   [LANES];
  logic                 dneg [LANES];

  out_item_t out_d;
  logic [LANES-1:0][WORD_BITS-1:0] rvec;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  assign a_v = {in_data_i.a_w, in_data_i.a_z, in_data_i.a_y, in_data_i.a_x};
  assign b_v = {in_data_i.b_w, in_data_i.b_z, in_data_i.b_y, in_data_i.b_x};

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vla_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .op_i   (in_data_i.operation),
      .a_i    ($signed(a_v[i])),
      .b_i    ($signed(b_v[i])),
      .s_i    (in_data_i.scale_factor),
      .tol_i  (tol_q),
      .vec_o  (lvec[i]),
      .prod_o (lprod[i]),
      .eq_o   (leq[i]),
      .near_o (lnear[i]),
      .aneg_o (laneg[i]),
      .amag_o (lamag[i])
    );
  end

  // Front control: valid bits follow the lane stages, then the adder tree.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vp_q <= 1'b0;
      vt_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      vp_q <= v2_q;
      vt_q <= vp_q;
    end
  end

  // Merge lanes: one tree sums dot products and squares alike.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q   <= in_data_i.operation;
      op2_q   <= op1_q;
      opp_q   <= op2_q;
      pair0_q <= ACC_BITS'(lprod[0]) + ACC_BITS'(lprod[1]);
      pair1_q <= ACC_BITS'(lprod[2]) + ACC_BITS'(lprod[3]);
      for (int i = 0; i < LANES; i++) begin
        vecp_q[i] <= lvec[i];
      end
      eqp_q   <= &leq;
      nearp_q <= &lnear;
      anegp_q <= laneg;
      amagp_q <= lamag;
      opt_q   <= opp_q;
      total_q <= pair0_q + pair1_q;
      vect_q  <= vecp_q;
      eqt_q   <= eqp_q;
      neart_q <= nearp_q;
      anegt_q <= anegp_q;
      amagt_q <= amagp_q;
    end
  end

  always_comb begin
    side_in        = '0;
    side_in.valid  = vt_q;
    side_in.op     = opt_q;
    side_in.vec    = vect_q;
    side_in.scalar = (opt_q == OP_DOT) ? sat_word(round_frac(total_q)) : '0;
    side_in.eq     = eqt_q;
    side_in.near   = neart_q;
    side_in.aneg   = anegt_q;
    side_in.amag   = amagt_q;
  end

  vla_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .n_i    ({1'b0, total_q[ACC_BITS-2:0]}),
    .root_o (root_c),
    .rem_o  (rem_c)
  );

  // Round the root to nearest: bump when remainder exceeds the root.
  assign m_c = root_c + ROOT_BITS'(rem_c > REM_BITS'(root_c));

  always_comb begin
    side_patch       = side_q[MZ_TAP-1];
    side_patch.mzero = (m_c == '0);
    if (side_patch.op == OP_MAG) begin
      side_patch.scalar = (m_c > ROOT_BITS'(WMAX_ACC)) ? WMAX_ACC[WORD_BITS-1:0]
                                                      : m_c[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SIDE_DEPTH; i++) begin
        side_q[i] <= '0;
      end
    end else if (adv) begin
      side_q[0] <= side_in;
      for (int i = 1; i < SIDE_DEPTH; i++) begin
        if (i == MZ_TAP) begin
          side_q[i] <= side_patch;
        end else begin
          side_q[i] <= side_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q <= m_c;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_div
    vla_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .m_i   (m_q),
      .mag_i (side_q[MZ_TAP].amag[i]),
      .neg_i (side_q[MZ_TAP].aneg[i]),
      .q_o   (dq[i]),
      .neg_o (dneg[i])
    );
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (side_q[SIDE_DEPTH-1].op == OP_NORM) begin
        if (side_q[SIDE_DEPTH-1].mzero) begin
          rvec[i] = '0;
        end else if (dneg[i]) begin
          rvec[i] = WORD_BITS'(0) - WORD_BITS'(dq[i]);
        end else begin
          rvec[i] = WORD_BITS'(dq[i]);
        end
      end else begin
        rvec[i] = side_q[SIDE_DEPTH-1].vec[i];
      end
    end
    out_d.r_x               = rvec[0];
    out_d.r_y               = rvec[1];
    out_d.r_z               = rvec[2];
    out_d.r_w               = rvec[3];
    out_d.scalar_out        = side_q[SIDE_DEPTH-1].scalar;
    out_d.exact_equal       = side_q[SIDE_DEPTH-1].eq;
    out_d.near_equal        = side_q[SIDE_DEPTH-1].near;
    out_d.zero_length_error = (side_q[SIDE_DEPTH-1].op == OP_NORM) &&
                              side_q[SIDE_DEPTH-1].mzero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= side_q[SIDE_DEPTH-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o <= out_d;
    end
  end

endmodule

// File: rtl/vla_lane.sv
// One vector lane: add, sub, negate, compare and the lane multiplier.
// Depends on vla_pkg. Two register stages, advanced by en_i.
module vla_lane import vla_pkg::*; (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  op_e                         op_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  input  logic signed [WORD_BITS-1:0] s_i,
  input  logic [TOL_BITS-1:0]         tol_i,
  output logic signed [WORD_BITS-1:0] vec_o,
  output logic signed [PROD_BITS-1:0] prod_o,
  output logic                        eq_o,
  output logic                        near_o,
  output logic                        aneg_o,
  output logic [WORD_BITS-1:0]        amag_o
);

  logic signed [WORD_BITS:0]   sum_c, dif_c, neg_c;
  logic [WORD_BITS:0]          dmag_c;
  logic signed [WORD_BITS-1:0] mop_c, simple_c;
  logic signed [PROD_BITS-1:0] prod_c;

  op_e                         op1_q;
  logic signed [PROD_BITS-1:0] prod1_q;
  logic signed [WORD_BITS-1:0] simple1_q;
  logic                        eq1_q, near1_q, aneg1_q;
  logic [WORD_BITS-1:0]        amag1_q;

  assign sum_c  = (WORD_BITS+1)'(a_i) + (WORD_BITS+1)'(b_i);
  assign dif_c  = (WORD_BITS+1)'(a_i) - (WORD_BITS+1)'(b_i);
  assign neg_c  = -(WORD_BITS+1)'(a_i);
  assign dmag_c = dif_c[WORD_BITS] ? (WORD_BITS+1)'(-dif_c) : dif_c;

  always_comb begin
    case (op_i)
      OP_SCALE: mop_c = s_i;
      OP_DOT:   mop_c = b_i;
      default:  mop_c = a_i;
    endcase
  end

  assign prod_c = a_i * mop_c;

  always_comb begin
    case (op_i)
      OP_ADD:  simple_c = sat_word(ACC_BITS'(sum_c));
      OP_SUB:  simple_c = sat_word(ACC_BITS'(dif_c));
      OP_NEG:  simple_c = sat_word(ACC_BITS'(neg_c));
      default: simple_c = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q     <= op_i;
      prod1_q   <= prod_c;
      simple1_q <= simple_c;
      eq1_q     <= (dif_c == '0);
      near1_q   <= (dmag_c < (WORD_BITS+1)'(tol_i));
      aneg1_q   <= a_i[WORD_BITS-1];
      amag1_q   <= a_i[WORD_BITS-1] ? WORD_BITS'(-a_i) : a_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_o  <= (op1_q == OP_SCALE) ? sat_word(round_frac(ACC_BITS'(prod1_q))) : simple1_q;
      prod_o <= prod1_q;
      eq_o   <= (op1_q == OP_CMP) && eq1_q;
      near_o <= (op1_q == OP_CMP) && near1_q;
      aneg_o <= aneg1_q;
      amag_o <= amag1_q;
    end
  end

endmodule

// File: rtl/vla_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on vla_pkg. Returns root and remainder for rounding downstream.
module vla_sqrt import vla_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [ACC_BITS-1:0]  n_i,
  output logic [ROOT_BITS-1:0] root_o,
  output logic [REM_BITS-1:0]  rem_o
);

  logic [ROOT_BITS-1:0] root_q [SQRT_STAGES];
  logic [REM_BITS-1:0]  rem_q  [SQRT_STAGES];
  logic [ACC_BITS-1:0]  n_q    [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [ROOT_BITS-1:0] rp;
    logic [REM_BITS-1:0]  remp;
    logic [ACC_BITS-1:0]  np;
    logic [REM_BITS+1:0]  cur, trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rp   = '0;
      assign remp = '0;
      assign np   = n_i;
    end else begin : g_next
      assign rp   = root_q[k-1];
      assign remp = rem_q[k-1];
      assign np   = n_q[k-1];
    end

    // Bring down two bits, try subtracting 4*root + 1.
    assign cur   = {remp, np[ACC_BITS-1 -: 2]};
    assign trial = (REM_BITS+2)'({rp, 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {rp[ROOT_BITS-2:0], ge};
        rem_q[k]  <= ge ? REM_BITS'(cur - trial) : REM_BITS'(cur);
        n_q[k]    <= {np[ACC_BITS-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];
  assign rem_o  = rem_q[SQRT_STAGES-1];

endmodule

// File: rtl/vla_div.sv
// Per-lane restoring divider for normalize: round(|a| * 2^FRAC / m).
// Depends on vla_pkg. One setup stage, then one quotient bit per stage.
module vla_div import vla_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [ROOT_BITS-1:0] m_i,
  input  logic [WORD_BITS-1:0] mag_i,
  input  logic                 neg_i,
  output logic [QUO_BITS-1:0]  q_o,
  output logic                 neg_o
);

  logic [DIVD_BITS-1:0] rem_q [DIV_STAGES];
  logic [ROOT_BITS-1:0] m_q   [DIV_STAGES];
  logic [QUO_BITS-1:0]  q_q   [DIV_STAGES];
  logic                 neg_q [DIV_STAGES];

  // Adding m/2 up front turns the truncating divide into round-half-up.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DIVD_BITS'({mag_i, {FRAC_BITS{1'b0}}}) + DIVD_BITS'(m_i >> 1);
      m_q[0]   <= m_i;
      q_q[0]   <= '0;
      neg_q[0] <= neg_i;
    end
  end

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
    localparam int J = QUO_BITS - k;
    logic [TRIAL_BITS-1:0] trial;
    logic                  ge;
    logic [QUO_BITS-1:0]   qn;

    assign trial = TRIAL_BITS'(m_q[k-1]) << J;
    assign ge    = (TRIAL_BITS'(rem_q[k-1]) >= trial);

    always_comb begin
      qn    = q_q[k-1];
      qn[J] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DIVD_BITS'(TRIAL_BITS'(rem_q[k-1]) - trial) : rem_q[k-1];
        m_q[k]   <= m_q[k-1];
        q_q[k]   <= qn;
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  assign q_o   = q_q[DIV_STAGES-1];
  assign neg_o = neg_q[DIV_STAGES-1];

endmodule

// File: rtl/vla_chk.sv
// Port-level checker for the four-lane vector ALU, bound to the top level.
// Depends on vla_pkg and four_lane_vector_alu_top.
module vla_chk import vla_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output item changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  a_zero_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_length_error |->
      out_data_o.r_x == '0 && out_data_o.r_y == '0 && out_data_o.r_z == '0 &&
      out_data_o.r_w == '0 && out_data_o.scalar_out == '0 &&
      !out_data_o.exact_equal && !out_data_o.near_equal)
    else $error("zero-length normalize item has nonzero fields");

  a_cmp_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.exact_equal || out_data_o.near_equal) |->
      out_data_o.r_x == '0 && out_data_o.r_w == '0 &&
      out_data_o.scalar_out == '0 && !out_data_o.zero_length_error)
    else $error("compare item carries vector or scalar data");

endmodule

bind four_lane_vector_alu_top vla_chk u_vla_chk (.*);
